// ===== hdl/sha_pkg.sv =====
package sha_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PACK,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    localparam t_word InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hdl/sha256_hash_engine.sv =====
// SHA-256 engine, one message byte per input word.
// Input channel: i_valid / o_stall with i_msg_byte, i_byte_present and
// i_end_of_message. A word with neither a byte nor an end is dropped.
// Output channel: o_valid / i_stall, eight digest words H0..H7 after each
// message end, o_word_index counting 0..7 and o_last_word on H7.
// A four-entry queue sits between the input and the hash core, so input
// keeps flowing while the core compresses.
// A byte that does not fill a block is written to the queue and taken from
// it by the core when the core is idle, so such bytes flow at one per cycle
// while the core stays idle. Each full block is packed from its sixteen
// words, run through the rounds (one round per cycle in a single round
// unit) and added. End of message adds one or two compressions, then H0..H7.
// While the receiver stalls the current digest word holds and the core
// waits; input backs up in the queue and then o_stall rises.
// Synchronous reset loads the standard initial hash and an empty message.
module sha256_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    t_cmd cmd;
    logic cmd_valid, cmd_pop;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_msg_byte, .i_byte_present,
        .i_end_of_message, .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop), .o_cmd(cmd)
    );

    sha_core u_core (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop), .i_cmd(cmd),
        .o_valid, .i_stall, .o_digest_word, .o_word_index, .o_last_word
    );
endmodule

// ===== hdl/sha_front.sv =====
module sha_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_msg_byte,
    input  logic          i_byte_present,
    input  logic          i_end_of_message,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop,
    output sha_pkg::t_cmd o_cmd
);
    import sha_pkg::*;

    t_cmd                 r_q [QueueDepth];
    logic [QueuePtrW-1:0] r_wr, r_rd;
    logic [QueuePtrW:0]   r_cnt;
    logic                 push, pop;

    assign o_stall     = (r_cnt == (QueuePtrW+1)'(QueueDepth));
    // idle items (no byte, no end) are dropped here
    assign push        = i_valid && !o_stall && (i_byte_present || i_end_of_message);
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_pop;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{data: i_msg_byte, present: i_byte_present,
                           last: i_end_of_message};
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
        end
    end
endmodule

// ===== hdl/sha_core.sv =====
module sha_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    input  sha_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [31:0]   o_digest_word,
    output logic [2:0]    o_word_index,
    output logic          o_last_word
);
    import sha_pkg::*;

    t_word       r_buf [16];
    t_word       r_w [16];
    t_word       r_h [8];
    t_word       r_v [8];
    logic [60:0] r_count;
    logic [5:0]  r_rnd;
    logic [3:0]  r_pk;
    logic [2:0]  r_idx;
    logic [1:0]  r_pad;   // 0 none, 1 pad then length block, 2 length block only
    logic        r_fin;
    t_state      r_st, n_st;

    logic [5:0]  pos;
    logic [5:0]  pos_next;
    logic        take;
    t_word       w_t, t1, t2, s1, s0, ch, mj, g0, g1, wpk, bw;
    logic [63:0] bits;
    logic [5:0]  b;
    logic [7:0]  pb [4];

    assign pos  = r_count[5:0];
    assign pos_next = pos + 6'(i_cmd.present);
    assign bits = {r_count, 3'b000};
    assign take = (r_st == ST_IDLE) && i_cmd_valid;
    assign o_cmd_pop = take;

    // packing: padding is applied on the fly from the fill position
    always_comb begin
        bw = r_buf[r_pk];
        for (int k = 0; k < 4; k++) begin
            b = {r_pk, 2'(k)};
            if (r_pad == 2'd0)
                pb[k] = bw[8*(3-k) +: 8];
            else if (r_pad == 2'd2 && b >= 6'd56)
                pb[k] = bits[8*(63-b) +: 8];
            else if (r_pad == 2'd2 && pos >= 6'd56)
                pb[k] = 8'h00;
            else if (b == pos)
                pb[k] = 8'h80;
            else if (b > pos)
                pb[k] = (r_pad == 2'd1 || b < 6'd56) ? 8'h00 : bits[8*(63-b) +: 8];
            else
                pb[k] = bw[8*(3-k) +: 8];
        end
        wpk = {pb[0], pb[1], pb[2], pb[3]};
    end

    always_comb begin
        g1  = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        g0  = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_t = (r_rnd < 6'd16) ? r_w[0] : g1 + r_w[9] + g0 + r_w[0];
        s1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        s0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + s1 + ch + RoundK[r_rnd] + w_t;
        t2  = s0 + mj;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (take) begin
                    if (i_cmd.present && pos == 6'd63) n_st = ST_PACK;
                    else if (i_cmd.last)              n_st = ST_PACK;
                end
            end
            ST_PACK:  if (r_pk == 4'd15) n_st = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'd63) n_st = ST_ADD;
            ST_ADD: begin
                if (r_fin && r_pad != 2'd2) n_st = ST_PACK;
                else if (r_fin)             n_st = ST_EMIT;
                else                        n_st = ST_IDLE;
            end
            ST_EMIT:  if (!i_stall && r_idx == 3'd7) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_valid       = (r_st == ST_EMIT);
        o_digest_word = r_h[r_idx];
        o_word_index  = r_idx;
        o_last_word   = (r_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cmd.present) r_buf[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= i_cmd.data;
        if (r_st == ST_PACK) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= wpk;
        end
        if (r_st == ST_ROUND) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= w_t;
            for (int k = 7; k > 0; k--) r_v[k] <= r_v[k-1];
            r_v[4] <= r_v[3] + t1;
            r_v[0] <= t1 + t2;
        end
        if (r_st == ST_PACK && r_pk == 4'd15) begin
            for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
        end
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_count <= '0;
            r_rnd   <= '0;
            r_pk    <= '0;
            r_idx   <= '0;
            r_pad   <= '0;
            r_fin   <= 1'b0;
            for (int k = 0; k < 8; k++) r_h[k] <= InitH[k];
        end else begin
            r_st <= n_st;
            if (take) begin
                if (i_cmd.present) r_count <= r_count + 61'd1;
                r_fin <= i_cmd.last;
                // a full block after this byte is compressed plain first
                if (i_cmd.present && pos == 6'd63) r_pad <= 2'd0;
                else if (i_cmd.last)
                    r_pad <= (pos_next >= 6'd56) ? 2'd1 : 2'd2;
            end
            if (r_st == ST_PACK)  r_pk  <= r_pk + 4'd1;
            if (r_st == ST_ROUND) r_rnd <= r_rnd + 6'd1;
            if (r_st == ST_ADD) begin
                for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
                if (r_fin) begin
                    if (r_pad == 2'd0) r_pad <= (pos >= 6'd56) ? 2'd1 : 2'd2;
                    else if (r_pad == 2'd1) r_pad <= 2'd2;
                end
            end
            if (r_st == ST_EMIT && !i_stall) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    for (int k = 0; k < 8; k++) r_h[k] <= InitH[k];
                    r_count <= '0;
                    r_fin   <= 1'b0;
                    r_pad   <= '0;
                end
            end
        end
    end
endmodule
